// ===== src/rv32dec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32dec_pkg
// opcodes, mnemonic codes and the decoded result type for the rv32 decoder
// ----------------------------------------------------------------------------
package rv32dec_pkg;

    // major opcodes, bits 6..0
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] OPC_AMO    = 7'b0101111;

    // exact system words
    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
    localparam logic [31:0] WORD_URET   = 32'h0020_0073;
    localparam logic [31:0] WORD_SRET   = 32'h1020_0073;
    localparam logic [31:0] WORD_MRET   = 32'h3020_0073;

    // amo funct5, bits 31..27
    localparam logic [4:0] AMO_SWAP = 5'h01;
    localparam logic [4:0] AMO_ADD  = 5'h00;
    localparam logic [4:0] AMO_XOR  = 5'h04;
    localparam logic [4:0] AMO_AND  = 5'h0C;
    localparam logic [4:0] AMO_OR   = 5'h08;
    localparam logic [4:0] AMO_MIN  = 5'h10;
    localparam logic [4:0] AMO_MAX  = 5'h14;
    localparam logic [4:0] AMO_MINU = 5'h18;
    localparam logic [4:0] AMO_MAXU = 5'h1C;

    // funct3 values
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    // dense mnemonic codes
    localparam logic [5:0] MN_LUI     = 6'd0;
    localparam logic [5:0] MN_AUIPC   = 6'd1;
    localparam logic [5:0] MN_JAL     = 6'd2;
    localparam logic [5:0] MN_JALR    = 6'd3;
    localparam logic [5:0] MN_BEQ     = 6'd4;
    localparam logic [5:0] MN_BNE     = 6'd5;
    localparam logic [5:0] MN_BLT     = 6'd6;
    localparam logic [5:0] MN_BGE     = 6'd7;
    localparam logic [5:0] MN_BLTU    = 6'd8;
    localparam logic [5:0] MN_BGEU    = 6'd9;
    localparam logic [5:0] MN_LB      = 6'd10;
    localparam logic [5:0] MN_LH      = 6'd11;
    localparam logic [5:0] MN_LW      = 6'd12;
    localparam logic [5:0] MN_LBU     = 6'd13;
    localparam logic [5:0] MN_LHU     = 6'd14;
    localparam logic [5:0] MN_SB      = 6'd15;
    localparam logic [5:0] MN_SH      = 6'd16;
    localparam logic [5:0] MN_SW      = 6'd17;
    localparam logic [5:0] MN_ADDI    = 6'd18;
    localparam logic [5:0] MN_SLTI    = 6'd19;
    localparam logic [5:0] MN_SLTIU   = 6'd20;
    localparam logic [5:0] MN_XORI    = 6'd21;
    localparam logic [5:0] MN_ORI     = 6'd22;
    localparam logic [5:0] MN_ANDI    = 6'd23;
    localparam logic [5:0] MN_SLLI    = 6'd24;
    localparam logic [5:0] MN_SRLI    = 6'd25;
    localparam logic [5:0] MN_SRAI    = 6'd26;
    localparam logic [5:0] MN_ADD     = 6'd27;
    localparam logic [5:0] MN_SUB     = 6'd28;
    localparam logic [5:0] MN_SLL     = 6'd29;
    localparam logic [5:0] MN_SLT     = 6'd30;
    localparam logic [5:0] MN_SLTU    = 6'd31;
    localparam logic [5:0] MN_XOR     = 6'd32;
    localparam logic [5:0] MN_SRL     = 6'd33;
    localparam logic [5:0] MN_SRA     = 6'd34;
    localparam logic [5:0] MN_OR      = 6'd35;
    localparam logic [5:0] MN_AND     = 6'd36;
    localparam logic [5:0] MN_FENCE   = 6'd37;
    localparam logic [5:0] MN_CSRRW   = 6'd38;
    localparam logic [5:0] MN_CSRRS   = 6'd39;
    localparam logic [5:0] MN_CSRRC   = 6'd40;
    localparam logic [5:0] MN_CSRRWI  = 6'd41;
    localparam logic [5:0] MN_CSRRSI  = 6'd42;
    localparam logic [5:0] MN_CSRRCI  = 6'd43;
    localparam logic [5:0] MN_ECALL   = 6'd44;
    localparam logic [5:0] MN_EBREAK  = 6'd45;
    localparam logic [5:0] MN_URET    = 6'd46;
    localparam logic [5:0] MN_SRET    = 6'd47;
    localparam logic [5:0] MN_MRET    = 6'd48;
    localparam logic [5:0] MN_AMOSWAP = 6'd49;
    localparam logic [5:0] MN_AMOADD  = 6'd50;
    localparam logic [5:0] MN_AMOXOR  = 6'd51;
    localparam logic [5:0] MN_AMOAND  = 6'd52;
    localparam logic [5:0] MN_AMOOR   = 6'd53;
    localparam logic [5:0] MN_AMOMIN  = 6'd54;
    localparam logic [5:0] MN_AMOMAX  = 6'd55;
    localparam logic [5:0] MN_AMOMINU = 6'd56;
    localparam logic [5:0] MN_AMOMAXU = 6'd57;

    typedef struct packed {
        logic               is_valid;
        logic [5:0]         mnemonic;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [31:0] imm;
        logic [11:0]        csr;
    } t_decoded;

endpackage
`default_nettype wire

// ===== src/rv32_instruction_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32_instruction_decoder
// rv32i + a-extension amos (no lr/sc) + zicsr decoder: one instruction word in, one decoded beat out
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  input    in         i_valid / o_ready    i_instr_word
//  output   out        o_valid / i_ready    o_is_valid, o_mnemonic, o_dest_reg,
//                                           o_src1_reg, o_src2_reg,
//                                           o_immediate, o_csr_address
//
//  one beat per cycle sustained while i_ready is high; word register, then
//  result register, with one level of decode logic between them
//  reset clears the two stage valid flags only; payload registers are not reset
//  when the result register holds a beat that is not taken, it holds and the
//  word register fills; o_ready drops only when both stages are full and
//  i_ready is low
// ----------------------------------------------------------------------------
module rv32_instruction_decoder
    import rv32dec_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [31:0]        i_instr_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_is_valid,
    output logic [5:0]              o_mnemonic,
    output logic [4:0]              o_dest_reg,
    output logic [4:0]              o_src1_reg,
    output logic [4:0]              o_src2_reg,
    output logic signed [31:0]      o_immediate,
    output logic [11:0]             o_csr_address
);

    // stage 1: captured word
    logic        r_in_valid;
    logic [31:0] r_word;

    // stage 2: decoded result
    logic        r_out_valid;
    t_decoded    r_res;
    t_decoded    n_res;

    logic        adv_out;   // result register may load
    logic        adv_in;    // word register may load

    assign adv_out = !r_out_valid || i_ready;
    assign adv_in  = !r_in_valid || adv_out;
    assign o_ready = adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_word <= i_instr_word;
        end
        if (adv_out && r_in_valid) begin
            r_res <= n_res;
        end
    end

    // field slices of the captured word
    logic [6:0]         opc;
    logic [4:0]         rd;
    logic [2:0]         f3;
    logic [4:0]         rs1;
    logic [4:0]         rs2;
    logic               alt;
    logic signed [31:0] imm_i;
    logic signed [31:0] imm_s;
    logic signed [31:0] imm_b;
    logic signed [31:0] imm_j;
    logic signed [31:0] imm_u;
    logic signed [31:0] imm_sh;

    assign opc    = r_word[6:0];
    assign rd     = r_word[11:7];
    assign f3     = r_word[14:12];
    assign rs1    = r_word[19:15];
    assign rs2    = r_word[24:20];
    assign alt    = r_word[30];
    assign imm_i  = {{20{r_word[31]}}, r_word[31:20]};
    assign imm_s  = {{20{r_word[31]}}, r_word[31:25], r_word[11:7]};
    assign imm_b  = {{19{r_word[31]}}, r_word[31], r_word[7], r_word[30:25],
                     r_word[11:8], 1'b0};
    assign imm_j  = {{11{r_word[31]}}, r_word[31], r_word[19:12], r_word[20],
                     r_word[30:21], 1'b0};
    assign imm_u  = {r_word[31:12], 12'h000};
    assign imm_sh = {27'd0, rs2};

    always_comb begin
        n_res          = '0;
        n_res.is_valid = 1'b1;
        unique case (opc)
            OPC_LUI: begin
                n_res.mnemonic = MN_LUI;
                n_res.rd       = rd;
                n_res.imm      = imm_u;
            end
            OPC_AUIPC: begin
                n_res.mnemonic = MN_AUIPC;
                n_res.rd       = rd;
                n_res.imm      = imm_u;
            end
            OPC_JAL: begin
                n_res.mnemonic = MN_JAL;
                n_res.rd       = rd;
                n_res.imm      = imm_j;
            end
            OPC_JALR: begin
                n_res.mnemonic = MN_JALR;
                n_res.rd       = rd;
                n_res.rs1      = rs1;
                n_res.imm      = imm_i;
                n_res.is_valid = (f3 == F3_0);
            end
            OPC_BRANCH: begin
                n_res.rs1 = rs1;
                n_res.rs2 = rs2;
                n_res.imm = imm_b;
                unique case (f3)
                    F3_0:    n_res.mnemonic = MN_BEQ;
                    F3_1:    n_res.mnemonic = MN_BNE;
                    F3_4:    n_res.mnemonic = MN_BLT;
                    F3_5:    n_res.mnemonic = MN_BGE;
                    F3_6:    n_res.mnemonic = MN_BLTU;
                    F3_7:    n_res.mnemonic = MN_BGEU;
                    default: n_res.is_valid = 1'b0;
                endcase
            end
            OPC_LOAD: begin
                n_res.rd  = rd;
                n_res.rs1 = rs1;
                n_res.imm = imm_i;
                unique case (f3)
                    F3_0:    n_res.mnemonic = MN_LB;
                    F3_1:    n_res.mnemonic = MN_LH;
                    F3_2:    n_res.mnemonic = MN_LW;
                    F3_4:    n_res.mnemonic = MN_LBU;
                    F3_5:    n_res.mnemonic = MN_LHU;
                    default: n_res.is_valid = 1'b0;
                endcase
            end
            OPC_STORE: begin
                n_res.rs1 = rs1;
                n_res.rs2 = rs2;
                n_res.imm = imm_s;
                unique case (f3)
                    F3_0:    n_res.mnemonic = MN_SB;
                    F3_1:    n_res.mnemonic = MN_SH;
                    F3_2:    n_res.mnemonic = MN_SW;
                    default: n_res.is_valid = 1'b0;
                endcase
            end
            OPC_OPIMM: begin
                n_res.rd  = rd;
                n_res.rs1 = rs1;
                n_res.imm = imm_i;
                unique case (f3)
                    F3_0: n_res.mnemonic = MN_ADDI;
                    F3_1: begin
                        n_res.mnemonic = MN_SLLI;
                        n_res.imm      = imm_sh;
                    end
                    F3_2: n_res.mnemonic = MN_SLTI;
                    F3_3: n_res.mnemonic = MN_SLTIU;
                    F3_4: n_res.mnemonic = MN_XORI;
                    F3_5: begin
                        n_res.mnemonic = alt ? MN_SRAI : MN_SRLI;
                        n_res.imm      = imm_sh;
                    end
                    F3_6: n_res.mnemonic = MN_ORI;
                    F3_7: n_res.mnemonic = MN_ANDI;
                endcase
            end
            OPC_OP: begin
                n_res.rd  = rd;
                n_res.rs1 = rs1;
                n_res.rs2 = rs2;
                unique case (f3)
                    F3_0: n_res.mnemonic = alt ? MN_SUB : MN_ADD;
                    F3_1: n_res.mnemonic = MN_SLL;
                    F3_2: n_res.mnemonic = MN_SLT;
                    F3_3: n_res.mnemonic = MN_SLTU;
                    F3_4: n_res.mnemonic = MN_XOR;
                    F3_5: n_res.mnemonic = alt ? MN_SRA : MN_SRL;
                    F3_6: n_res.mnemonic = MN_OR;
                    F3_7: n_res.mnemonic = MN_AND;
                endcase
            end
            OPC_FENCE: begin
                n_res.mnemonic = MN_FENCE;
                n_res.is_valid = (f3 == F3_0);
            end
            OPC_SYSTEM: begin
                if (f3 == F3_0 || f3 == F3_4) begin
                    // environment and trap-return words match exactly
                    priority if (r_word == WORD_ECALL) begin
                        n_res.mnemonic = MN_ECALL;
                    end else if (r_word == WORD_EBREAK) begin
                        n_res.mnemonic = MN_EBREAK;
                    end else if (r_word == WORD_URET) begin
                        n_res.mnemonic = MN_URET;
                    end else if (r_word == WORD_SRET) begin
                        n_res.mnemonic = MN_SRET;
                    end else if (r_word == WORD_MRET) begin
                        n_res.mnemonic = MN_MRET;
                    end else begin
                        n_res.is_valid = 1'b0;
                    end
                end else begin
                    n_res.rd  = rd;
                    n_res.rs1 = rs1;
                    n_res.csr = r_word[31:20];
                    unique case (f3)
                        F3_1:    n_res.mnemonic = MN_CSRRW;
                        F3_2:    n_res.mnemonic = MN_CSRRS;
                        F3_3:    n_res.mnemonic = MN_CSRRC;
                        F3_5:    n_res.mnemonic = MN_CSRRWI;
                        F3_6:    n_res.mnemonic = MN_CSRRSI;
                        F3_7:    n_res.mnemonic = MN_CSRRCI;
                        default: n_res.is_valid = 1'b0;
                    endcase
                end
            end
            OPC_AMO: begin
                n_res.rd  = rd;
                n_res.rs1 = rs1;
                n_res.rs2 = rs2;
                unique case (r_word[31:27])
                    AMO_SWAP: n_res.mnemonic = MN_AMOSWAP;
                    AMO_ADD:  n_res.mnemonic = MN_AMOADD;
                    AMO_XOR:  n_res.mnemonic = MN_AMOXOR;
                    AMO_AND:  n_res.mnemonic = MN_AMOAND;
                    AMO_OR:   n_res.mnemonic = MN_AMOOR;
                    AMO_MIN:  n_res.mnemonic = MN_AMOMIN;
                    AMO_MAX:  n_res.mnemonic = MN_AMOMAX;
                    AMO_MINU: n_res.mnemonic = MN_AMOMINU;
                    AMO_MAXU: n_res.mnemonic = MN_AMOMAXU;
                    default:  n_res.is_valid = 1'b0;
                endcase
            end
            default: n_res.is_valid = 1'b0;
        endcase
        // unknown words report all-zero fields
        if (!n_res.is_valid) begin
            n_res = '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_valid    = r_res.is_valid;
    assign o_mnemonic    = r_res.mnemonic;
    assign o_dest_reg    = r_res.rd;
    assign o_src1_reg    = r_res.rs1;
    assign o_src2_reg    = r_res.rs2;
    assign o_immediate   = r_res.imm;
    assign o_csr_address = r_res.csr;

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat presented right after reset");

    // a filled word register moves on whenever the result register frees up
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv_out |=> o_valid)
        else $error("decoded beat lost between stages");

    // an unknown word carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_valid |-> (o_mnemonic == 6'd0 && o_dest_reg == 5'd0 &&
        o_src1_reg == 5'd0 && o_src2_reg == 5'd0 && o_immediate == 32'sd0 &&
        o_csr_address == 12'd0))
        else $error("invalid decode with nonzero fields");

    // a nonzero csr number only comes with a csr mnemonic
    a_csr_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_csr_address != 12'd0 |-> (o_mnemonic == MN_CSRRW ||
        o_mnemonic == MN_CSRRS || o_mnemonic == MN_CSRRC ||
        o_mnemonic == MN_CSRRWI || o_mnemonic == MN_CSRRSI ||
        o_mnemonic == MN_CSRRCI))
        else $error("csr address on a non-csr instruction");

    // mnemonic stays within the dense code range
    a_mn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mnemonic <= MN_AMOMAXU)
        else $error("mnemonic code out of range");

endmodule
`default_nettype wire
